/* rtl/core/phrr_pkg.sv */
// Shared types and constants of the per-host round-robin work scheduler.
// Used by the front, the back and the top level; depends on nothing.
package phrr_pkg;

    localparam int MAX_HOSTS_DEF = 16;
    localparam int MAX_CONNS_DEF = 16;
    localparam int CONN_ID_BITS_DEF = 16;

    localparam logic [1:0] KIND_OPEN    = 2'd0;
    localparam logic [1:0] KIND_WORK    = 2'd1;
    localparam logic [1:0] KIND_REQUEST = 2'd2;
    localparam logic [1:0] KIND_CLOSE   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_WORK = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_LIMIT   = 3'd4;

    // Item as handed from the front to the back.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [15:0] conn;
    } item_t;

endpackage

/* rtl/core/phrr_front.sv */
// Front part: accepts items into a two-entry queue ahead of the back part.
// Depends on phrr_pkg.
module phrr_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     kind,
    input  logic [31:0]    host_addr,
    input  logic [15:0]    conn_id,
    output logic           q_valid,
    input  logic           q_take,
    output phrr_pkg::item_t q_item
);
    import phrr_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
    assign wr      = push && !full;
    assign rd      = q_take && q_valid;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= '{kind: kind, addr: host_addr, conn: conn_id};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("front queue count out of range");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && !wr) |=> cnt_reg == 2'd0)
        else $error("front queue grew without a transfer");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !rd) |=> full) else $error("full dropped without a read");
`endif
endmodule

/* rtl/core/phrr_back.sv */
// Back part: host table lookup, per-host ready FIFOs and the host ring.
// Depends on phrr_pkg; produces one result per item into a result register.
module phrr_back
#(
    parameter int MAX_HOSTS    = phrr_pkg::MAX_HOSTS_DEF,
    parameter int MAX_CONNS    = phrr_pkg::MAX_CONNS_DEF,
    parameter int CONN_ID_BITS = phrr_pkg::CONN_ID_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_take,
    input  phrr_pkg::item_t q_item,
    output logic            empty,
    input  logic            pop,
    output logic [2:0]      status,
    output logic [15:0]     granted_conn,
    output logic [31:0]     granted_host
);
    import phrr_pkg::*;

    localparam int HB = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
    localparam int CB = (MAX_CONNS > 1) ? $clog2(MAX_CONNS) : 1;
    localparam int CNTB = $clog2(MAX_CONNS + 1);
    localparam int RFB = $clog2(MAX_HOSTS + 1);
    localparam int DEPTH = MAX_HOSTS * MAX_CONNS;
    localparam int AB = $clog2(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_OUT} state_t;

    state_t                  state_reg;
    item_t                   it_reg;
    logic [MAX_HOSTS-1:0]    valid_reg;
    logic [31:0]             addr_reg  [MAX_HOSTS];
    logic [CNTB-1:0]         cnt_reg   [MAX_HOSTS];
    logic [CB-1:0]           head_reg  [MAX_HOSTS];
    logic [CNTB-1:0]         fill_reg  [MAX_HOSTS];
    logic [HB-1:0]           ring_reg  [MAX_HOSTS];
    logic [HB-1:0]           rhead_reg;
    logic [RFB-1:0]          rfill_reg;
    logic [CONN_ID_BITS-1:0] conns_mem [DEPTH];
    logic [CONN_ID_BITS-1:0] rdata_reg;
    logic                    hit_reg, free_ok_reg;
    logic [HB-1:0]           hit_idx_reg, free_idx_reg, gh_reg;
    logic [2:0]              st_reg;
    logic [15:0]             gc_reg;
    logic [31:0]             ga_reg;
    logic                    out_reg;

    // Lookup of the incoming item over the table, registered as it is taken.
    logic          hit_c, free_ok_c;
    logic [HB-1:0] hit_c_idx, free_c_idx;
    always_comb
    begin
        hit_c = 1'b0; free_ok_c = 1'b0; hit_c_idx = '0; free_c_idx = '0;
        for (int h = MAX_HOSTS - 1; h >= 0; h--)
        begin
            if (valid_reg[h] && addr_reg[h] == q_item.addr)
            begin
                hit_c = 1'b1; hit_c_idx = HB'(h);
            end
            if (!valid_reg[h])
            begin
                free_ok_c = 1'b1; free_c_idx = HB'(h);
            end
        end
    end

    assign q_take = (state_reg == S_IDLE) && !out_reg;
    assign empty  = !out_reg;
    assign status = st_reg;
    assign granted_conn = gc_reg;
    assign granted_host = ga_reg;

    logic [31:0]   rsum, wsum;
    logic [HB-1:0] rtail;
    logic [HB-1:0] rh_host;
    logic [CB-1:0] wslot;
    // Both sums stay below twice the modulus, so one compare and subtract wraps them.
    assign rsum    = 32'(rhead_reg) + 32'(rfill_reg);
    assign rtail   = HB'((rsum >= 32'(MAX_HOSTS)) ? rsum - 32'(MAX_HOSTS) : rsum);
    assign rh_host = ring_reg[rhead_reg];
    assign wsum    = 32'(head_reg[hit_idx_reg]) + 32'(fill_reg[hit_idx_reg]);
    assign wslot   = CB'((wsum >= 32'(MAX_CONNS)) ? wsum - 32'(MAX_CONNS) : wsum);

    always_ff @(posedge clk)
    begin
        if (q_take && q_valid) it_reg <= q_item;
        if (state_reg == S_IDLE)
        begin
            hit_reg <= hit_c; hit_idx_reg <= hit_c_idx;
            free_ok_reg <= free_ok_c; free_idx_reg <= free_c_idx;
        end
        if (state_reg == S_EXEC && it_reg.kind == KIND_WORK && hit_reg
            && fill_reg[hit_idx_reg] < cnt_reg[hit_idx_reg]
            && 32'(fill_reg[hit_idx_reg]) < MAX_CONNS)
        begin
            conns_mem[AB'(32'(hit_idx_reg) * MAX_CONNS + 32'(wslot))]
                <= it_reg.conn[CONN_ID_BITS-1:0];
        end
        // The head of the FIFO of the host at the ring head, used by a request.
        rdata_reg <= conns_mem[AB'(32'(rh_host) * MAX_CONNS + 32'(head_reg[rh_host]))];
        if (state_reg == S_EXEC && it_reg.kind == KIND_OPEN && !hit_reg && free_ok_reg)
            addr_reg[free_idx_reg] <= it_reg.addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            for (int h = 0; h < MAX_HOSTS; h++)
            begin
                cnt_reg[h] <= '0; head_reg[h] <= '0; fill_reg[h] <= '0;
                ring_reg[h] <= '0;
            end
            rhead_reg <= '0; rfill_reg <= '0;
            out_reg <= 1'b0; st_reg <= ST_OK; gc_reg <= '0; ga_reg <= '0;
            gh_reg <= '0;
        end
        else
        begin
            if (pop && out_reg) out_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_take && q_valid) state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    st_reg <= ST_OK; gc_reg <= '0; ga_reg <= '0;
                    state_reg <= S_OUT;
                    case (it_reg.kind)
                        KIND_OPEN:
                        begin
                            if (hit_reg)
                            begin
                                if (32'(cnt_reg[hit_idx_reg]) >= MAX_CONNS) st_reg <= ST_LIMIT;
                                else cnt_reg[hit_idx_reg] <= cnt_reg[hit_idx_reg] + 1'b1;
                            end
                            else if (!free_ok_reg) st_reg <= ST_FULL;
                            else
                            begin
                                valid_reg[free_idx_reg] <= 1'b1;
                                cnt_reg[free_idx_reg]  <= CNTB'(1);
                                head_reg[free_idx_reg] <= '0;
                                fill_reg[free_idx_reg] <= '0;
                            end
                        end
                        KIND_WORK:
                        begin
                            if (!hit_reg) st_reg <= ST_UNKNOWN;
                            else if (fill_reg[hit_idx_reg] >= cnt_reg[hit_idx_reg]
                                     || 32'(fill_reg[hit_idx_reg]) >= MAX_CONNS)
                                st_reg <= ST_LIMIT;
                            else
                            begin
                                fill_reg[hit_idx_reg] <= fill_reg[hit_idx_reg] + 1'b1;
                                if (fill_reg[hit_idx_reg] == '0 && 32'(rfill_reg) < MAX_HOSTS)
                                begin
                                    ring_reg[rtail] <= hit_idx_reg;
                                    rfill_reg <= rfill_reg + 1'b1;
                                end
                            end
                        end
                        KIND_REQUEST:
                        begin
                            if (rfill_reg == '0) st_reg <= ST_NO_WORK;
                            else
                            begin
                                rhead_reg <= (32'(rhead_reg) == MAX_HOSTS - 1)
                                             ? '0 : rhead_reg + 1'b1;
                                rfill_reg <= rfill_reg - 1'b1;
                                if (!valid_reg[rh_host] || fill_reg[rh_host] == '0)
                                    st_reg <= ST_LIMIT;
                                else
                                begin
                                    gh_reg <= rh_host;
                                    state_reg <= S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            if (!hit_reg) st_reg <= ST_UNKNOWN;
                            else if (cnt_reg[hit_idx_reg] == '0
                                     || fill_reg[hit_idx_reg] >= cnt_reg[hit_idx_reg])
                                st_reg <= ST_LIMIT;
                            else
                            begin
                                cnt_reg[hit_idx_reg] <= cnt_reg[hit_idx_reg] - 1'b1;
                                if (cnt_reg[hit_idx_reg] == CNTB'(1))
                                begin
                                    valid_reg[hit_idx_reg] <= 1'b0;
                                    head_reg[hit_idx_reg] <= '0;
                                    fill_reg[hit_idx_reg] <= '0;
                                end
                            end
                        end
                    endcase
                end
                S_READ:
                begin
                    // rdata_reg now holds the head of the chosen host's FIFO.
                    gc_reg <= 16'(rdata_reg);
                    ga_reg <= addr_reg[gh_reg];
                    head_reg[gh_reg] <= (32'(head_reg[gh_reg]) == MAX_CONNS - 1)
                                        ? '0 : head_reg[gh_reg] + 1'b1;
                    fill_reg[gh_reg] <= fill_reg[gh_reg] - 1'b1;
                    if (fill_reg[gh_reg] != CNTB'(1) && 32'(rfill_reg) < MAX_HOSTS)
                    begin
                        ring_reg[rtail] <= gh_reg;
                        rfill_reg <= rfill_reg + 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                default:
                begin
                    out_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rfill_reg) <= MAX_HOSTS) else $error("ring fill beyond table size");
    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> !out_reg) else $error("result overwritten");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> state_reg == S_IDLE) else $error("item taken while busy");
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_reg && st_reg != ST_OK) |-> gc_reg == '0 && ga_reg == '0)
        else $error("grant shown with error status");
`endif
endmodule

/* rtl/core/per_host_round_robin_work_scheduler.sv */
// Top level of the per-host round-robin work scheduler.
// Instantiates phrr_front and phrr_back; depends on phrr_pkg.
//
// Items enter through a two-entry queue and are carried out one at a time by
// the back part. Open, work and close pass through the back part as load with
// table lookup, update and result; a work request adds a registered read of the
// ready-connection memory between update and result. The result register holds
// one result until it is popped, and the back part takes the next item only
// after that; the input queue keeps taking up to two items meanwhile.
module per_host_round_robin_work_scheduler
#(
    parameter int MAX_HOSTS          = phrr_pkg::MAX_HOSTS_DEF,
    parameter int MAX_CONNS_PER_HOST = phrr_pkg::MAX_CONNS_DEF,
    parameter int CONN_ID_BITS       = phrr_pkg::CONN_ID_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [31:0] host_addr,
    input  logic [15:0] conn_id,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [15:0] granted_conn,
    output logic [31:0] granted_host
);
    import phrr_pkg::*;

    logic  q_valid, q_take;
    item_t q_item;

    phrr_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .host_addr(host_addr), .conn_id(conn_id), .q_valid(q_valid),
        .q_take(q_take), .q_item(q_item)
    );

    phrr_back #(
        .MAX_HOSTS(MAX_HOSTS), .MAX_CONNS(MAX_CONNS_PER_HOST),
        .CONN_ID_BITS(CONN_ID_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_item(q_item), .empty(empty), .pop(pop), .status(status),
        .granted_conn(granted_conn), .granted_host(granted_host)
    );
endmodule
